// ----- design/rrt_pkg.sv -----
// shared types, codes and sizes of the round-robin worker table
package rrt_pkg;

   localparam int POOL_SIZE = 16;
   localparam int ID_WIDTH  = 16;

   localparam int OP_W      = 3;
   localparam int FIELD_W   = 16;
   localparam int CODE_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int ID_KEEP_W = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;
   localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int COUNT_W   = $clog2(POOL_SIZE + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 3'd0,
      OP_PICK     = 3'd1,
      OP_ASSIGN   = 3'd2,
      OP_COMPLETE = 3'd3,
      OP_MAINT    = 3'd4,
      OP_RELEASE  = 3'd5
   } rrt_op_type;

   localparam logic [CODE_W-1:0] RC_OK       = 3'd0;
   localparam logic [CODE_W-1:0] RC_FULL     = 3'd1;
   localparam logic [CODE_W-1:0] RC_DUP      = 3'd2;
   localparam logic [CODE_W-1:0] RC_NOTFOUND = 3'd3;
   localparam logic [CODE_W-1:0] RC_NOTAVAIL = 3'd4;
   localparam logic [CODE_W-1:0] RC_NOTBUSY  = 3'd5;
   localparam logic [CODE_W-1:0] RC_EMPTY    = 3'd6;
   localparam logic [CODE_W-1:0] RC_NONE     = 3'd7;

   localparam logic [STATUS_W-1:0] SL_AVAILABLE = 2'd0;
   localparam logic [STATUS_W-1:0] SL_BUSY      = 2'd1;
   localparam logic [STATUS_W-1:0] SL_MAINT     = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FIELD_W-1:0] worker_id;
      logic [FIELD_W-1:0] order_id;
   } rrt_req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  result_code;
      logic [FIELD_W-1:0] picked_id;
      logic [FIELD_W-1:0] finished_order;
   } rrt_rsp_type;

   typedef struct packed {
      logic [ID_KEEP_W-1:0] id;
      logic [STATUS_W-1:0]  status;
      logic [FIELD_W-1:0]   order;
   } rrt_entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } rrt_cmd_type;

   typedef struct packed {
      logic scan_done;
   } rrt_stat_type;

endpackage

// ----- design/rrt_ctrl.sv -----
// sequencer: accept, slot scan, commit and answer
module rrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output rrt_pkg::rrt_cmd_type cmd,
   input  rrt_pkg::rrt_stat_type stat
);
   import rrt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- design/rrt_datapath.sv -----
// slot memory, scan pointers, pool counters and result register
module rrt_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rrt_pkg::rrt_cmd_type  cmd,
   input  rrt_pkg::rrt_req_type  req_data,
   output rrt_pkg::rrt_stat_type stat,
   output logic                  rsp_valid,
   output rrt_pkg::rrt_rsp_type  rsp_data
);
   import rrt_pkg::*;

   rrt_entry_type mem [POOL_SIZE];

   rrt_req_type          req_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [SLOT_W-1:0]    ptr_ff;
   logic [SLOT_W-1:0]    ptr_in;
   logic [COUNT_W-1:0]   issued_ff;
   logic [SLOT_W-1:0]    addr_ff;
   logic [SLOT_W-1:0]    addr_in;
   logic                 rd_vld_ff;
   logic [SLOT_W-1:0]    rd_idx_ff;
   rrt_entry_type        rd_entry_ff;
   logic                 hit_ff;
   logic [SLOT_W-1:0]    hit_idx_ff;
   rrt_entry_type        hit_entry_ff;
   logic                 rsp_valid_ff;
   rrt_rsp_type          rsp_ff;
   rrt_rsp_type          rsp_in;

   logic                 issue;
   logic                 match;
   logic [ID_KEEP_W-1:0] req_id;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_idx;
   rrt_entry_type        wr_entry;

   assign req_id = req_ff.worker_id[ID_KEEP_W-1:0];
   assign issue  = cmd.scan && (issued_ff != count_ff);

   // pick looks for an available slot, every other operation for the id
   assign match = (req_ff.operation == OP_PICK) ? (rd_entry_ff.status == SL_AVAILABLE)
                                                : (rd_entry_ff.id == req_id);

   assign stat.scan_done = hit_ff || (!rd_vld_ff && (issued_ff == count_ff));

   // scan wraps over the occupied slots only
   always_comb begin
      if ((COUNT_W'(addr_ff) + COUNT_W'(1)) == count_ff) begin
         addr_in = '0;
      end else begin
         addr_in = SLOT_W'(addr_ff + SLOT_W'(1));
      end
   end

   always_comb begin
      rsp_in   = '0;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      wr_en    = 1'b0;
      wr_idx   = hit_idx_ff;
      wr_entry = hit_entry_ff;
      rsp_in.result_code = RC_OK;
      case (req_ff.operation) inside
         OP_ADD: begin
            if (count_ff == COUNT_W'(POOL_SIZE)) begin
               rsp_in.result_code = RC_FULL;
            end else if (hit_ff) begin
               rsp_in.result_code = RC_DUP;
            end else begin
               wr_en           = 1'b1;
               wr_idx          = SLOT_W'(count_ff);
               wr_entry.id     = req_id;
               wr_entry.status = SL_AVAILABLE;
               wr_entry.order  = '0;
               count_in        = COUNT_W'(count_ff + COUNT_W'(1));
            end
         end
         OP_PICK: begin
            if (count_ff == '0) begin
               rsp_in.result_code = RC_EMPTY;
            end else if (hit_ff) begin
               rsp_in.picked_id = FIELD_W'(hit_entry_ff.id);
               if ((COUNT_W'(hit_idx_ff) + COUNT_W'(1)) == count_ff) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = SLOT_W'(hit_idx_ff + SLOT_W'(1));
               end
            end else begin
               rsp_in.result_code = RC_NONE;
            end
         end
         OP_ASSIGN, OP_COMPLETE, OP_MAINT, OP_RELEASE: begin
            if (!hit_ff) begin
               rsp_in.result_code = RC_NOTFOUND;
            end else begin
               case (req_ff.operation)
                  OP_ASSIGN: begin
                     if (hit_entry_ff.status != SL_AVAILABLE) begin
                        rsp_in.result_code = RC_NOTAVAIL;
                     end else begin
                        wr_en           = 1'b1;
                        wr_entry.status = SL_BUSY;
                        wr_entry.order  = req_ff.order_id;
                     end
                  end
                  OP_COMPLETE: begin
                     if (hit_entry_ff.status != SL_BUSY) begin
                        rsp_in.result_code = RC_NOTBUSY;
                     end else begin
                        rsp_in.finished_order = hit_entry_ff.order;
                        wr_en           = 1'b1;
                        wr_entry.status = SL_AVAILABLE;
                        wr_entry.order  = '0;
                     end
                  end
                  OP_MAINT: begin
                     wr_en           = 1'b1;
                     wr_entry.status = SL_MAINT;
                     wr_entry.order  = '0;
                  end
                  default: begin
                     wr_en           = 1'b1;
                     wr_entry.status = SL_AVAILABLE;
                     wr_entry.order  = '0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.finish && wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (issue) begin
         rd_entry_ff <= mem[addr_ff];
         rd_idx_ff   <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (rd_vld_ff && match && !hit_ff) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_entry_ff <= rd_entry_ff;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         issued_ff    <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.load) begin
            issued_ff <= '0;
            rd_vld_ff <= 1'b0;
            hit_ff    <= 1'b0;
            addr_ff   <= (req_data.operation == OP_PICK) ? ptr_ff : '0;
         end else begin
            rd_vld_ff <= issue;
            if (issue) begin
               issued_ff <= COUNT_W'(issued_ff + COUNT_W'(1));
               addr_ff   <= addr_in;
            end
            if (rd_vld_ff && match) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            count_ff <= count_in;
            ptr_ff   <= ptr_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/resource_pool_round_robin_table.sv -----
// top level of the round-robin worker table
//
//   channel   ports                          handshake
//   request   req_data                       start high while busy low
//   result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//
// busy stays high while a word is in work: the slot scan reads
// the slot memory once per cycle over the occupied slots and stops at the
// first hit. the result word shows in the first cycle with busy low, and a
// new word may be started in that same cycle. reset empties the pool and
// zeroes the pick pointer; slot contents are left as they are.
module resource_pool_round_robin_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rrt_pkg::rrt_req_type req_data,
   output logic                 rsp_valid,
   output rrt_pkg::rrt_rsp_type rsp_data
);
   import rrt_pkg::*;

   rrt_cmd_type  cmd;
   rrt_stat_type stat;

   rrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   rrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/rrt_checker.sv -----
// port-level checks of the worker table, bound to the top level
module rrt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input rrt_pkg::rrt_rsp_type rsp_data
);
   import rrt_pkg::*;

   // an accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // busy only starts from an accepted word
   a_no_spurious_busy: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("busy rose without a start");

   // each answer closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $fell(busy))
      else $error("result word without end of busy");

   // error answers carry no id and no order
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_code != RC_OK))
         |-> ((rsp_data.picked_id == '0) && (rsp_data.finished_order == '0)))
      else $error("error result word with nonzero fields");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind resource_pool_round_robin_table rrt_checker u_rrt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ----- tb/tb.sv -----
// testbench for the round-robin worker table: directed and random words checked by a predictor
module tb;
   import rrt_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int WORDS_PER_PHASE = 250;
   localparam int DRAIN_CYCLES    = 2 * POOL_SIZE + 8;

   class pool_scoreboard;
      logic [ID_KEEP_W-1:0] slot_id    [POOL_SIZE];
      logic [STATUS_W-1:0]  slot_state [POOL_SIZE];
      logic [FIELD_W-1:0]   slot_order [POOL_SIZE];
      int occupied = 0;
      int pointer  = 0;
      int failures = 0;
      rrt_rsp_type pending [$];

      function int slot_of(logic [ID_KEEP_W-1:0] id);
         for (int i = 0; i < occupied; i++)
            if (slot_id[i] == id) return i;
         return occupied;
      endfunction

      function void note_word(rrt_req_type w);
         rrt_rsp_type r;
         logic [ID_KEEP_W-1:0] id;
         int s;
         int first;
         int idx;
         r = '0;
         id = w.worker_id[ID_KEEP_W-1:0];
         s = slot_of(id);
         case (w.operation)
            OP_ADD: begin
               if (occupied >= POOL_SIZE) r.result_code = RC_FULL;
               else if (s != occupied) r.result_code = RC_DUP;
               else begin
                  slot_id[occupied]    = id;
                  slot_state[occupied] = SL_AVAILABLE;
                  slot_order[occupied] = '0;
                  occupied++;
               end
            end
            OP_PICK: begin
               if (occupied == 0) r.result_code = RC_EMPTY;
               else begin
                  r.result_code = RC_NONE;
                  first = pointer % occupied;
                  for (int i = 0; i < occupied; i++) begin
                     idx = (first + i) % occupied;
                     if (slot_state[idx] == SL_AVAILABLE) begin
                        r.result_code = RC_OK;
                        r.picked_id   = FIELD_W'(slot_id[idx]);
                        pointer       = (idx + 1) % occupied;
                        break;
                     end
                  end
               end
            end
            OP_ASSIGN, OP_COMPLETE, OP_MAINT, OP_RELEASE: begin
               if (s >= occupied) r.result_code = RC_NOTFOUND;
               else begin
                  case (w.operation)
                     OP_ASSIGN: begin
                        if (slot_state[s] != SL_AVAILABLE) r.result_code = RC_NOTAVAIL;
                        else begin
                           slot_state[s] = SL_BUSY;
                           slot_order[s] = w.order_id;
                        end
                     end
                     OP_COMPLETE: begin
                        if (slot_state[s] != SL_BUSY) r.result_code = RC_NOTBUSY;
                        else begin
                           r.finished_order = slot_order[s];
                           slot_state[s]    = SL_AVAILABLE;
                           slot_order[s]    = '0;
                        end
                     end
                     OP_MAINT: begin
                        slot_state[s] = SL_MAINT;
                        slot_order[s] = '0;
                     end
                     default: begin
                        slot_state[s] = SL_AVAILABLE;
                        slot_order[s] = '0;
                     end
                  endcase
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_word(rrt_rsp_type got);
         rrt_rsp_type want;
         if (pending.size() == 0) begin
            $error("result word with none expected: %h", got);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (got.result_code !== want.result_code) begin
            $error("result_code expected %0d actual %0d", want.result_code, got.result_code);
            failures++;
         end
         if (got.picked_id !== want.picked_id) begin
            $error("picked_id expected %h actual %h", want.picked_id, got.picked_id);
            failures++;
         end
         if (got.finished_order !== want.finished_order) begin
            $error("finished_order expected %h actual %h", want.finished_order,
                   got.finished_order);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   rrt_req_type req_data;
   logic        rsp_valid;
   rrt_rsp_type rsp_data;

   pool_scoreboard sb;
   int gap_pct;

   resource_pool_round_robin_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_word(rsp_data);
   end

   function automatic rrt_req_type word_of(logic [OP_W-1:0] op, logic [FIELD_W-1:0] id,
                                           logic [FIELD_W-1:0] order);
      rrt_req_type w;
      w.operation = op;
      w.worker_id = id;
      w.order_id  = order;
      return w;
   endfunction

   function automatic logic [FIELD_W-1:0] some_worker_id();
      if (sb.occupied == 0 || $urandom_range(9) == 0) return FIELD_W'($urandom);
      return FIELD_W'(sb.slot_id[$urandom_range(sb.occupied - 1)]);
   endfunction

   task automatic send_word(input rrt_req_type w);
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= word_of(OP_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_word(w);
   endtask

   initial begin
      rrt_req_type w;
      int roll;
      sb       = new;
      gap_pct  = 16;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(word_of(OP_PICK,     16'h0000, 16'h0000));
      send_word(word_of(OP_ASSIGN,   16'h0000, 16'h1234));
      send_word(word_of(OP_ADD,      16'h0000, 16'hffff));
      send_word(word_of(OP_ADD,      16'hffff, 16'h0000));
      send_word(word_of(OP_ADD,      16'h0000, 16'h0000));
      send_word(word_of(OP_PICK,     16'hffff, 16'hffff));
      send_word(word_of(OP_PICK,     16'h0000, 16'h0000));
      send_word(word_of(OP_PICK,     16'h0000, 16'h0000));
      send_word(word_of(OP_ASSIGN,   16'h0000, 16'hffff));
      send_word(word_of(OP_ASSIGN,   16'h0000, 16'h0000));
      send_word(word_of(OP_PICK,     16'h0000, 16'h0000));
      send_word(word_of(OP_COMPLETE, 16'hffff, 16'h0000));
      send_word(word_of(OP_COMPLETE, 16'h0000, 16'h0000));
      send_word(word_of(OP_MAINT,    16'hffff, 16'h0000));
      send_word(word_of(OP_ASSIGN,   16'hffff, 16'h5555));
      send_word(word_of(OP_COMPLETE, 16'hffff, 16'h0000));
      send_word(word_of(OP_MAINT,    16'h0000, 16'h0000));
      send_word(word_of(OP_PICK,     16'h0000, 16'h0000));
      send_word(word_of(OP_RELEASE,  16'hffff, 16'h0000));
      send_word(word_of(OP_COMPLETE, 16'h5a5a, 16'h0000));
      send_word(word_of(OP_MAINT,    16'h5a5a, 16'h0000));
      send_word(word_of(OP_RELEASE,  16'ha5a5, 16'h0000));
      send_word(word_of(OP_SPARE_LO, 16'hffff, 16'hffff));
      send_word(word_of(OP_SPARE_HI, 16'hffff, 16'hffff));
      send_word(word_of(OP_RELEASE,  16'h0000, 16'h0000));

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 16 : (phase == 1) ? 75 : 0;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            w.worker_id = some_worker_id();
            w.order_id  = FIELD_W'($urandom);
            if (roll < 6) begin
               w.operation = OP_ADD;
               if ($urandom_range(9) < 7) w.worker_id = FIELD_W'($urandom);
            end
            else if (roll < 30) w.operation = OP_PICK;
            else if (roll < 55) w.operation = OP_ASSIGN;
            else if (roll < 75) w.operation = OP_COMPLETE;
            else if (roll < 84) w.operation = OP_MAINT;
            else if (roll < 96) w.operation = OP_RELEASE;
            else w.operation = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
            send_word(w);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
